>>> rtl/core/first_fit_slot_allocator_defines.svh
// Assertion macros used by the allocator checker.
// Bodies use clk_i and rst_ni from the scope where the macro is expanded.
`ifndef FIRST_FIT_SLOT_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_SLOT_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, quiet while in reset.
`define FFSA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, quiet while in reset.
`define FFSA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/ffsa_pkg.sv
// Package for the first-fit slot allocator: sizes, codes and request/result types.
// No dependencies; imported by the allocator top level, its checker and testbench.
`timescale 1ns / 1ps
`default_nettype none

package ffsa_pkg;

  localparam int SLOTS      = 1024;
  localparam int OWNER_BITS = 16;
  localparam int SLOT_AW    = $clog2(SLOTS);
  localparam int CNT_W      = SLOT_AW + 1;
  localparam int LOT_W      = 11;
  localparam int FEE_W      = 16;
  localparam int LEN_W      = 11;
  localparam int START_W    = 10;
  localparam int REV_W      = 32;
  localparam int OWNER_W    = 16;

  localparam logic [LOT_W-1:0] LOT_RESET = LOT_W'(1024);
  localparam logic [FEE_W-1:0] FEE_RESET = FEE_W'(10);
  localparam logic [REV_W-1:0] REV_MAX   = '1;

  // request kinds
  localparam logic KIND_ALLOC   = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  // register index, taken from paddr[2]
  localparam logic REG_LOT = 1'b0;
  localparam logic REG_FEE = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [OWNER_W-1:0] owner;
    logic [LEN_W-1:0]   run_length;
  } ffsa_req_t;

  typedef struct packed {
    logic               granted;
    logic [START_W-1:0] start_slot;
    logic [REV_W-1:0]   revenue_total;
  } ffsa_rsp_t;

endpackage

`default_nettype wire

>>> rtl/core/first_fit_slot_allocator.sv
// First-fit slot allocator: a store of SLOTS owner tags (0 = free) in one
// single-port-write, single-port-read memory, walked one slot per cycle by a small
// sequencer. After reset the block stalls requests while it clears the memory.
// An allocate request scans the lot (the first lot_length slots, at most SLOTS)
// from slot 0 and then tags the first free run it found. A release walks the whole
// store. A request with owner 0 (or an allocate of length 0) goes straight to its
// result without touching the memory. The result sits in an output register, so
// the next request is taken while it waits. Registers: lot_length at 0x0,
// fee_per_allocation at 0x4.
`timescale 1ns / 1ps
`default_nettype none

module first_fit_slot_allocator
  import ffsa_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // request channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire ffsa_req_t   in_req_i,
  // result channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output ffsa_rsp_t        out_rsp_o,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FILL,
    ST_RELEASE,
    ST_DONE
  } state_e;

  state_e                  state_q;
  logic [LOT_W-1:0]        lot_q;
  logic [FEE_W-1:0]        fee_q;
  logic [REV_W-1:0]        revenue_q;
  logic [CNT_W-1:0]        rd_idx_q;
  logic [CNT_W-1:0]        limit_q;
  logic                    pend_q;
  logic [SLOT_AW-1:0]      pend_idx_q;
  logic [LEN_W-1:0]        run_q;
  logic [LEN_W-1:0]        len_q;
  logic [OWNER_BITS-1:0]   tag_q;
  logic [SLOT_AW-1:0]      fill_idx_q;
  logic [LEN_W-1:0]        fill_left_q;
  logic                    granted_q;
  logic [SLOT_AW-1:0]      start_q;
  logic                    out_valid_q;
  ffsa_rsp_t               out_q;

  logic [OWNER_BITS-1:0]   slot_mem_q [SLOTS];
  logic [OWNER_BITS-1:0]   rdata_q;
  logic                    mem_we;
  logic [SLOT_AW-1:0]      mem_waddr;
  logic [OWNER_BITS-1:0]   mem_wdata;

  logic                    in_acc;
  logic                    issue;
  logic                    rd_free;
  logic                    run_hit;
  logic [LOT_W-1:0]        lot_use;
  logic [OWNER_BITS-1:0]   in_tag;
  logic [REV_W:0]          rev_sum;
  logic                    cfg_we;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign in_tag  = OWNER_BITS'(in_req_i.owner);
  assign lot_use = (lot_q > LOT_W'(SLOTS)) ? LOT_W'(SLOTS) : lot_q;
  assign issue   = ((state_q == ST_SCAN) || (state_q == ST_RELEASE)) && (rd_idx_q < limit_q);
  assign rd_free = (rdata_q == '0);
  assign run_hit = pend_q && rd_free && ((run_q + LEN_W'(1)) == len_q);
  assign rev_sum = {1'b0, revenue_q} + (REV_W + 1)'(fee_q);

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // one write port: clear sweep, run fill, or release of a matching slot
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = rd_idx_q[SLOT_AW-1:0];
    mem_wdata = '0;
    unique case (state_q)
      ST_CLEAR: mem_we = 1'b1;
      ST_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = fill_idx_q;
        mem_wdata = tag_q;
      end
      ST_RELEASE: begin
        mem_we    = pend_q && (rdata_q == tag_q);
        mem_waddr = pend_idx_q;
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= slot_mem_q[rd_idx_q[SLOT_AW-1:0]];
  end

  // configuration port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[2])
      REG_LOT: prdata = 32'(lot_q);
      REG_FEE: prdata = 32'(fee_q);
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lot_q <= LOT_RESET;
      fee_q <= FEE_RESET;
    end else if (cfg_we) begin
      unique case (paddr[2])
        REG_LOT: lot_q <= pwdata[LOT_W-1:0];
        REG_FEE: fee_q <= pwdata[FEE_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      revenue_q   <= '0;
      rd_idx_q    <= '0;
      limit_q     <= '0;
      pend_q      <= 1'b0;
      pend_idx_q  <= '0;
      run_q       <= '0;
      len_q       <= '0;
      tag_q       <= '0;
      fill_idx_q  <= '0;
      fill_left_q <= '0;
      granted_q   <= 1'b0;
      start_q     <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      // ST_DONE owns out_valid_q while it loads a result
      if (out_valid_q && !out_stall_i && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_CLEAR: begin
          rd_idx_q <= rd_idx_q + CNT_W'(1);
          if (rd_idx_q == CNT_W'(SLOTS - 1)) begin
            state_q <= ST_IDLE;
          end
        end

        ST_IDLE: begin
          if (in_acc) begin
            tag_q     <= in_tag;
            len_q     <= in_req_i.run_length;
            rd_idx_q  <= '0;
            pend_q    <= 1'b0;
            run_q     <= '0;
            granted_q <= 1'b0;
            start_q   <= '0;
            if (in_tag == '0) begin
              state_q <= ST_DONE;
            end else if (in_req_i.kind == KIND_RELEASE) begin
              limit_q <= CNT_W'(SLOTS);
              state_q <= ST_RELEASE;
            end else if (in_req_i.run_length == '0) begin
              state_q <= ST_DONE;
            end else begin
              limit_q <= CNT_W'(lot_use);
              state_q <= ST_SCAN;
            end
          end
        end

        ST_SCAN: begin
          if (issue) begin
            rd_idx_q <= rd_idx_q + CNT_W'(1);
          end
          pend_q     <= issue;
          pend_idx_q <= rd_idx_q[SLOT_AW-1:0];
          if (pend_q) begin
            run_q <= rd_free ? run_q + LEN_W'(1) : '0;
          end
          if (run_hit) begin
            // run ends at the slot just read
            start_q     <= pend_idx_q + SLOT_AW'(1) - SLOT_AW'(len_q);
            fill_idx_q  <= pend_idx_q + SLOT_AW'(1) - SLOT_AW'(len_q);
            fill_left_q <= len_q;
            state_q     <= ST_FILL;
          end else if (!pend_q && !issue) begin
            state_q <= ST_DONE;
          end
        end

        ST_FILL: begin
          fill_idx_q  <= fill_idx_q + SLOT_AW'(1);
          fill_left_q <= fill_left_q - LEN_W'(1);
          if (fill_left_q == LEN_W'(1)) begin
            granted_q <= 1'b1;
            revenue_q <= rev_sum[REV_W] ? REV_MAX : rev_sum[REV_W-1:0];
            state_q   <= ST_DONE;
          end
        end

        ST_RELEASE: begin
          if (issue) begin
            rd_idx_q <= rd_idx_q + CNT_W'(1);
          end
          pend_q     <= issue;
          pend_idx_q <= rd_idx_q[SLOT_AW-1:0];
          if (!pend_q && !issue) begin
            state_q <= ST_DONE;
          end
        end

        ST_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q         <= 1'b1;
            out_q.granted       <= granted_q;
            out_q.start_slot    <= START_W'(start_q);
            out_q.revenue_total <= revenue_q;
            state_q             <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/ffsa_checker.sv
// Port-level checker for the first-fit slot allocator, bound to the top level.
// Depends on ffsa_pkg and first_fit_slot_allocator_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "first_fit_slot_allocator_defines.svh"

module ffsa_checker
  import ffsa_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_stall_o,
  input wire logic      out_valid_o,
  input wire logic      out_stall_i,
  input wire ffsa_rsp_t out_rsp_o
);

  // block works on one request at a time
  `FFSA_ASSERT_NXT(a_busy_after_req, in_valid_i && !in_stall_o, in_stall_o, "request taken while busy")

  `FFSA_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "result dropped under stall")

  `FFSA_ASSERT_NXT(a_out_stable, out_valid_o && out_stall_i, $stable(out_rsp_o), "result changed under stall")

  // a refused or release result reports slot 0
  `FFSA_ASSERT_IMP(a_start_zero, out_valid_o && !out_rsp_o.granted, out_rsp_o.start_slot == '0, "start_slot set without grant")

endmodule

bind first_fit_slot_allocator ffsa_checker u_ffsa_checker (.*);

`default_nettype wire

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// Testbench for first_fit_slot_allocator: directed, random and backpressure requests.
// Results are checked in order against a slot map kept here; depends on ffsa_pkg and the RTL.
module tb_top;
  import ffsa_pkg::*;

  localparam int unsigned RUN_LIMIT        = 5_000_000;
  localparam int unsigned DRAIN_CYCLES     = 2 * SLOTS + 64;
  localparam int unsigned SHOWN_MISMATCHES = 10;
  localparam int unsigned POOL_SIZE        = 8;
  localparam int unsigned RING_DEPTH       = 16;

  logic        clk_i;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  ffsa_req_t   in_req_i    = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  ffsa_rsp_t   out_rsp_o;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [2:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;
  logic [31:0] prdata;
  logic        pready;

  // slot map and registers as the block should hold them
  logic [OWNER_W-1:0] slot_tag [SLOTS];
  logic [REV_W-1:0]   revenue  = '0;
  logic [LOT_W-1:0]   lot_cfg  = LOT_RESET;
  logic [FEE_W-1:0]   fee_cfg  = FEE_RESET;

  // expected results in request order
  ffsa_rsp_t          want_ring [RING_DEPTH];
  logic [3:0]         want_wr     = '0;
  logic [3:0]         want_rd     = '0;
  logic [OWNER_W-1:0] owner_pool [POOL_SIZE];
  int unsigned        mismatches  = 0;
  int unsigned        hold_cycles = 0;
  bit                 idle_on     = 1'b1;

  first_fit_slot_allocator u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < RUN_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= SHOWN_MISMATCHES) begin
      $display("mismatch at %0t: %s", $time, what);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      note_mismatch($sformatf("%s expected %0d actual %0d", name, want, got));
    end
  endtask

  // First fit over the lot, or release of every slot holding the tag.
  function automatic ffsa_rsp_t book_slots(input ffsa_req_t req);
    ffsa_rsp_t   rsp;
    int unsigned span;
    int unsigned run;
    int unsigned first;
    int unsigned want_len;
    bit          found;
    rsp      = '0;
    run      = 0;
    first    = 0;
    found    = 1'b0;
    want_len = 32'(req.run_length);
    span     = (lot_cfg > LOT_W'(SLOTS)) ? SLOTS : 32'(lot_cfg);
    if (req.kind == KIND_RELEASE) begin
      if (req.owner != '0) begin
        foreach (slot_tag[i]) begin
          if (slot_tag[i] == req.owner) slot_tag[i] = '0;
        end
      end
    end else if (req.owner != '0 && want_len != 0) begin
      for (int i = 0; i < span && !found; i++) begin
        if (slot_tag[i] != '0) begin
          run = 0;
        end else begin
          run++;
          if (run == want_len) begin
            first = i + 1 - run;
            found = 1'b1;
          end
        end
      end
      if (found) begin
        for (int i = first; i < first + want_len; i++) slot_tag[i] = req.owner;
        if (REV_MAX - revenue < REV_W'(fee_cfg)) revenue = REV_MAX;
        else revenue = revenue + REV_W'(fee_cfg);
      end
    end
    rsp.granted       = found;
    rsp.start_slot    = found ? START_W'(first) : '0;
    rsp.revenue_total = revenue;
    return rsp;
  endfunction

  initial begin : result_sink
    ffsa_rsp_t   want;
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o === 1'b1 && !out_stall_i) begin
        if (want_wr == want_rd) begin
          note_mismatch("result with no request pending");
        end else begin
          want    = want_ring[want_rd];
          want_rd = want_rd + 4'd1;
          check_field("granted", 32'(want.granted), 32'(out_rsp_o.granted));
          check_field("start_slot", 32'(want.start_slot), 32'(out_rsp_o.start_slot));
          check_field("revenue_total", want.revenue_total, out_rsp_o.revenue_total);
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_stall_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 14);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // valid stays high into the next request unless a gap is drawn
  task automatic send_request(input ffsa_req_t req);
    int unsigned gap;
    gap = (idle_on && $urandom_range(0, 7) == 0) ? $urandom_range(1, 15) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    want_ring[want_wr] = book_slots(req);
    want_wr            = want_wr + 4'd1;
  endtask

  task automatic request(input logic kind, input logic [OWNER_W-1:0] owner,
                         input logic [LEN_W-1:0] len);
    ffsa_req_t req;
    req.kind       = kind;
    req.owner      = owner;
    req.run_length = len;
    send_request(req);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (want_wr != want_rd) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // setup, access, then an idle phase with psel low before the next transfer
  task automatic apb_access(input logic wr, input logic idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] value);
    logic [31:0] rd;
    logic [31:0] held;
    apb_access(1'b1, idx, value, rd);
    if (idx == REG_LOT) begin
      lot_cfg = value[LOT_W-1:0];
      held    = 32'(lot_cfg);
    end else begin
      fee_cfg = value[FEE_W-1:0];
      held    = 32'(fee_cfg);
    end
    apb_access(1'b0, idx, '0, rd);
    check_field(idx == REG_LOT ? "lot_length readback" : "fee readback", held, rd);
  endtask

  function automatic ffsa_req_t random_request();
    ffsa_req_t   req;
    int unsigned r;
    int unsigned span;
    span           = (lot_cfg > LOT_W'(SLOTS)) ? SLOTS : 32'(lot_cfg);
    r              = $urandom_range(0, 99);
    req.kind       = KIND_ALLOC;
    req.owner      = owner_pool[$urandom_range(0, POOL_SIZE - 1)];
    req.run_length = LEN_W'($urandom_range(1, span / 4 + 1));
    if (r >= 60 && r < 85) begin
      req.kind       = KIND_RELEASE;
      req.run_length = LEN_W'($urandom);
    end else if (r >= 85) begin
      // malformed or off-pool requests
      case (r % 5)
        0: begin
          req.owner = '0;
          req.kind  = $urandom_range(0, 1) ? KIND_RELEASE : KIND_ALLOC;
        end
        1: req.run_length = '0;
        2: req.run_length = LEN_W'($urandom);
        3: begin
          req.kind  = KIND_RELEASE;
          req.owner = OWNER_W'($urandom);
        end
        default: begin
          req.owner      = OWNER_W'($urandom);
          req.run_length = LEN_W'($urandom_range(1, span + 1));
        end
      endcase
    end
    return req;
  endfunction

  task automatic test_reset_values();
    logic [31:0] rd;
    apb_access(1'b0, REG_LOT, '0, rd);
    check_field("lot_length after reset", 32'(LOT_RESET), rd);
    apb_access(1'b0, REG_FEE, '0, rd);
    check_field("fee after reset", 32'(FEE_RESET), rd);
  endtask

  // default lot of the whole store, fee 10; leaves the store empty
  task automatic test_directed();
    request(KIND_ALLOC, 16'h0001, 11'd1);
    request(KIND_ALLOC, 16'hFFFF, 11'd1024);   // one slot short
    request(KIND_ALLOC, 16'h0002, 11'd1023);   // fills the store
    request(KIND_ALLOC, 16'h0003, 11'd1);
    request(KIND_RELEASE, 16'h0001, LEN_W'($urandom));
    request(KIND_RELEASE, 16'h0001, LEN_W'($urandom));
    request(KIND_RELEASE, 16'h1234, LEN_W'($urandom));
    request(KIND_ALLOC, 16'h0000, 11'd1);
    request(KIND_RELEASE, 16'h0000, 11'h7FF);
    request(KIND_ALLOC, 16'h0005, 11'd0);
    request(KIND_ALLOC, 16'h0005, 11'h7FF);
    request(KIND_ALLOC, 16'h0007, 11'd1);
    request(KIND_RELEASE, 16'h0002, 11'd0);
    request(KIND_ALLOC, 16'h0007, 11'd3);      // same owner, second and third runs
    request(KIND_ALLOC, 16'h0007, 11'd3);
    request(KIND_ALLOC, 16'hFFFF, 11'd1017);
    request(KIND_RELEASE, 16'h0007, LEN_W'($urandom));
    request(KIND_RELEASE, 16'hFFFF, LEN_W'($urandom));
    request(KIND_ALLOC, 16'h8000, 11'd1024);
    request(KIND_RELEASE, 16'h8000, LEN_W'($urandom));
  endtask

  task automatic test_lot_and_fee_extremes();
    settle();
    write_reg(REG_LOT, 32'd0);
    request(KIND_ALLOC, 16'h00AA, 11'd1);
    settle();
    write_reg(REG_LOT, 32'd1);
    write_reg(REG_FEE, 32'd0);
    request(KIND_ALLOC, 16'h0101, 11'd1);
    request(KIND_ALLOC, 16'h0102, 11'd1);
    request(KIND_ALLOC, 16'h0102, 11'd2);
    request(KIND_RELEASE, 16'h0101, 11'd0);
    settle();
    write_reg(REG_LOT, 32'd2047);              // above the store size
    write_reg(REG_FEE, 32'd65535);
    request(KIND_ALLOC, 16'h7FFF, 11'd1024);
    request(KIND_ALLOC, 16'h7FFE, 11'd1);
    request(KIND_RELEASE, 16'h7FFF, 11'd1);
  endtask

  task automatic test_random_phase(input int unsigned count, input logic [LOT_W-1:0] lot,
                                   input logic [FEE_W-1:0] fee);
    settle();
    write_reg(REG_LOT, 32'(lot));
    write_reg(REG_FEE, 32'(fee));
    foreach (owner_pool[i]) owner_pool[i] = OWNER_W'($urandom_range(1, 16'hFFFF));
    repeat (count) send_request(random_request());
  endtask

  // sink holds off while requests keep coming, so the block backs up
  task automatic test_backpressure();
    bit saved_idle;
    settle();
    write_reg(REG_LOT, 32'd32);
    write_reg(REG_FEE, 32'd7);
    saved_idle  = idle_on;
    idle_on     = 1'b0;
    hold_cycles = 400;
    repeat (14) request(KIND_ALLOC, owner_pool[$urandom_range(0, POOL_SIZE - 1)],
                        LEN_W'($urandom_range(1, 3)));
    request(KIND_RELEASE, owner_pool[0], 11'd5);
    request(KIND_RELEASE, owner_pool[1], 11'd0);
    idle_on = saved_idle;
  endtask

  initial begin : main_seq
    foreach (slot_tag[i]) slot_tag[i] = '0;
    foreach (owner_pool[i]) owner_pool[i] = OWNER_W'(i + 1);
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_values();
    test_directed();
    test_lot_and_fee_extremes();
    test_random_phase(80, 11'd64, 16'd3);
    test_random_phase(50, 11'd1024, 16'hFFFF);
    test_random_phase(80, LOT_W'($urandom_range(2, 300)), FEE_W'($urandom));
    test_backpressure();
    test_random_phase(40, 11'd1, 16'd0);
    test_random_phase(50, LOT_W'($urandom_range(1025, 2047)), 16'd1);
    idle_on = 1'b0;
    test_random_phase(100, 11'd128, FEE_W'($urandom));
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/ffsa_pkg.sv
rtl/core/first_fit_slot_allocator.sv
rtl/core/ffsa_checker.sv
verif/tb_top.sv
